// File: hw/rtl/amx_pkg.sv
package amx_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_IN_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF     = 24;

  // Fixed field and register widths
  localparam int NSLOT      = 6;
  localparam int NTYPE      = 10;
  localparam int LAYOUT_W   = 3;
  localparam int CNT_W      = 4;
  localparam int MAP_W      = 32;
  localparam int TYPE_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int CHAN_W     = 3;
  localparam int COEF_W     = 16;
  localparam int DEN_W      = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_LAYOUT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAP      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PASS     = 2'd3;

  // Output layouts
  localparam logic [LAYOUT_W-1:0] LAYOUT_MONO   = 3'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO = 3'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_2F1R   = 3'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F     = 3'd3;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F1R   = 3'd4;
  localparam logic [LAYOUT_W-1:0] LAYOUT_2F2R   = 3'd5;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F2R   = 3'd6;
  localparam logic [LAYOUT_W-1:0] LAYOUT_3F2R_L = 3'd7;

  // Q1.15 mixing coefficients
  typedef logic [COEF_W-1:0] coef_t;
  localparam coef_t C0 = 16'd0;
  localparam coef_t CU = 16'd32768;  // 1.0
  localparam coef_t CH = 16'd23167;  // 0.707
  localparam coef_t CF = 16'd19497;  // 0.595
  localparam coef_t CL = 16'd16384;  // 0.5
  localparam coef_t CT = 16'd15041;  // 0.459

  // Coefficient rows indexed by [layout-1][channel type][output slot]
  localparam coef_t COEF_TAB [0:6][0:NTYPE-1][0:NSLOT-1] = '{
    '{ '{CH,CH,C0,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CH,CH,C0,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CH,CH,C0,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CH,CH,C0,C0,C0,C0} },
    '{ '{CH,CH,C0,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CH,CH,C0,C0,C0,C0}, '{C0,C0,CU,C0,C0,C0}, '{C0,C0,CU,C0,C0,C0},
       '{C0,C0,CU,C0,C0,C0}, '{CH,C0,CH,C0,C0,C0}, '{C0,CH,CH,C0,C0,C0},
       '{CF,CF,CF,C0,C0,C0} },
    '{ '{C0,C0,CU,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{C0,C0,CU,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{C0,C0,CU,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CF,CF,CF,C0,C0,C0} },
    '{ '{C0,C0,C0,CU,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{C0,C0,C0,CU,C0,C0}, '{C0,C0,CU,C0,C0,C0}, '{C0,C0,CU,C0,C0,C0},
       '{C0,C0,CU,C0,C0,C0}, '{CH,C0,CH,C0,C0,C0}, '{C0,CH,CH,C0,C0,C0},
       '{CL,CL,CL,CL,C0,C0} },
    '{ '{CH,CH,C0,C0,C0,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{CH,CH,C0,C0,C0,C0}, '{C0,C0,CU,C0,C0,C0}, '{C0,C0,C0,CU,C0,C0},
       '{C0,C0,CH,CH,C0,C0}, '{CH,C0,CH,C0,C0,C0}, '{C0,CH,C0,CH,C0,C0},
       '{CL,CL,CL,CL,C0,C0} },
    '{ '{C0,C0,C0,C0,CU,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{C0,C0,C0,C0,CU,C0}, '{C0,C0,CU,C0,C0,C0}, '{C0,C0,C0,CU,C0,C0},
       '{C0,C0,CH,CH,C0,C0}, '{CH,C0,CH,C0,C0,C0}, '{C0,CH,C0,CH,C0,C0},
       '{CT,CT,CT,CT,CT,C0} },
    '{ '{C0,C0,C0,C0,CU,C0}, '{CU,C0,C0,C0,C0,C0}, '{C0,CU,C0,C0,C0,C0},
       '{C0,C0,C0,C0,CU,C0}, '{C0,C0,CU,C0,C0,C0}, '{C0,C0,C0,CU,C0,C0},
       '{C0,C0,CH,CH,C0,C0}, '{CH,C0,CH,C0,C0,C0}, '{C0,CH,C0,CH,C0,C0},
       '{C0,C0,C0,C0,C0,CU} }
  };

  // Configuration as seen by controller and datapath
  typedef struct packed {
    logic [LAYOUT_W-1:0] layout;
    logic [CNT_W-1:0]    in_ch;
    logic [MAP_W-1:0]    chan_map;
    logic                pass;
  } amx_cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;       // capture the input sample
    logic              mul;        // multiply sample by slot coefficient
    logic              acc;        // add rounded product into slot
    logic              div_start;  // load mono divider
    logic              div_step;   // one quotient bit
    logic              emit;       // load output register from slot
    logic              pass;       // load output register from sample
    logic              last;       // last result of the frame
    logic              clear;      // clear all accumulators
    logic [SLOT_W-1:0] slot;
  } amx_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } amx_sts_t;

  // Coefficient for a channel type feeding an output slot
  function automatic coef_t coef_of(logic [LAYOUT_W-1:0] layout,
                                    logic [TYPE_W-1:0] typ,
                                    logic [SLOT_W-1:0] slot);
    coef_t c;
    c = C0;
    if (layout == LAYOUT_MONO) begin
      c = (slot == '0) ? CU : C0;
    end else if (typ < TYPE_W'(NTYPE) && slot < SLOT_W'(NSLOT)) begin
      c = COEF_TAB[layout - 3'd1][typ][slot];
    end
    return c;
  endfunction

  // Number of output slots of a layout
  function automatic logic [SLOT_W-1:0] slot_cnt(logic [LAYOUT_W-1:0] layout);
    logic [SLOT_W-1:0] n;
    unique case (layout)
      LAYOUT_MONO:   n = 3'd1;
      LAYOUT_STEREO: n = 3'd2;
      LAYOUT_2F1R:   n = 3'd3;
      LAYOUT_3F:     n = 3'd3;
      LAYOUT_3F1R:   n = 3'd4;
      LAYOUT_2F2R:   n = 3'd4;
      LAYOUT_3F2R:   n = 3'd5;
      LAYOUT_3F2R_L: n = 3'd6;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // Channels per frame, clamped to 1..mx
  function automatic logic [CNT_W-1:0] frame_count(logic [CNT_W-1:0] n, int mx);
    logic [CNT_W-1:0] c;
    c = n;
    if (n == '0) begin
      c = 4'd1;
    end else if ({1'b0, n} > 5'(mx)) begin
      c = CNT_W'(mx);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/amx_cfg.sv
module amx_cfg
  import amx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output amx_cfg_t              cfg
);

  amx_cfg_t cfg_r;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout   <= LAYOUT_STEREO;
      cfg_r.in_ch    <= 4'd2;
      cfg_r.chan_map <= 32'd33;
      cfg_r.pass     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LAYOUT:   cfg_r.layout   <= cfg_wdata[LAYOUT_W-1:0];
        REG_CHANNELS: cfg_r.in_ch    <= cfg_wdata[CNT_W-1:0];
        REG_MAP:      cfg_r.chan_map <= cfg_wdata[MAP_W-1:0];
        REG_PASS:     cfg_r.pass     <= cfg_wdata[0];
        default:      cfg_r.pass     <= cfg_r.pass;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/amx_dp.sv
module amx_dp
  import amx_pkg::*;
#(
  parameter int MAX_IN_CHANNELS = MAX_IN_CHANNELS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int POS_W           = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  amx_cfg_t                      cfg,
  input  amx_cmd_t                      cmd,
  output amx_sts_t                      sts,
  input  logic [POS_W-1:0]              pos,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic [CHAN_W-1:0]             out_channel,
  output logic                          out_last
);

  localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_IN_CHANNELS) + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
  localparam int TERM_W = PROD_W - 15;
  localparam int NUM_W  = ACC_W + 1;
  localparam int EXT_W  = ACC_W + 2;
  localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(16384);
  localparam logic signed [EXT_W-1:0]  SAT_HI = EXT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [EXT_W-1:0]  SAT_LO = -SAT_HI - EXT_W'(1);

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r [NSLOT];
  logic [NUM_W-1:0]              div_num_r;
  logic [DEN_W-1:0]              div_rem_r;
  logic                          div_neg_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHAN_W-1:0]             out_channel_r;
  logic                          out_last_r;

  logic [3:0]              pos4;
  logic [TYPE_W-1:0]       ch_type;
  logic signed [COEF_W:0]  coef_s;
  logic signed [PROD_W-1:0] rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sel;
  logic [CNT_W-1:0]        count;
  logic [DEN_W-1:0]        den;
  logic [DEN_W-1:0]        half;
  logic [ACC_W-1:0]        mag;
  logic [DEN_W:0]          rem_sh;
  logic                    q_bit;
  logic signed [EXT_W-1:0] quot_s;
  logic signed [EXT_W-1:0] mix_val;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  // Channel type from the map, unknown past its eight nibbles
  assign pos4    = 4'(pos);
  assign ch_type = (pos4 < 4'd8) ? cfg.chan_map[{pos4[2:0], 2'b00} +: TYPE_W] : 4'hF;
  assign coef_s  = {1'b0, coef_of(cfg.layout, ch_type, cmd.slot)};

  // Round the Q1.15 product to nearest, ties up
  assign rnd     = prod_r + ROUND;
  assign term    = rnd[PROD_W-1:15];
  assign acc_sel = acc_r[cmd.slot];

  // Mono divisor: channel count plus one, rounded down to even
  assign count = frame_count(cfg.in_ch, MAX_IN_CHANNELS);
  assign den   = ({1'b0, count} + 5'd1) & 5'b11110;
  assign half  = den >> 1;
  assign mag   = acc_r[0][ACC_W-1] ? ACC_W'(-acc_r[0]) : acc_r[0];

  // Restoring divider step
  assign rem_sh = {div_rem_r, div_num_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den});

  assign quot_s  = div_neg_r ? -$signed({1'b0, div_num_r}) : $signed({1'b0, div_num_r});
  assign mix_val = (cfg.layout == LAYOUT_MONO) ? quot_s : EXT_W'(acc_sel);

  // Saturate to the sample range
  always_comb begin
    if (mix_val > SAT_HI) begin
      mix_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (mix_val < SAT_LO) begin
      mix_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = mix_val[SAMPLE_BITS-1:0];
    end
  end

  // Sample, product and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sample_r) * PROD_W'(coef_s);
    end
    if (cmd.div_start) begin
      div_num_r <= {1'b0, mag} + NUM_W'(half);
      div_rem_r <= '0;
      div_neg_r <= acc_r[0][ACC_W-1];
    end else if (cmd.div_step) begin
      div_num_r <= {div_num_r[NUM_W-2:0], q_bit};
      div_rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    end
  end

  // Accumulators: add one slot at a time, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < NSLOT; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.acc) begin
      acc_r[cmd.slot] <= acc_sel + ACC_W'(term);
    end
  end

  // Output register: load on emit or passthrough, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.pass) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r  <= mix_sat;
      out_channel_r <= CHAN_W'(cmd.slot);
      out_last_r    <= cmd.last;
    end else if (cmd.pass) begin
      out_sample_r  <= sample_r;
      out_channel_r <= pos4[2:0];
      out_last_r    <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_channel  = out_channel_r;
  assign out_last     = out_last_r;

endmodule

// File: hw/rtl/amx_ctrl.sv
module amx_ctrl
  import amx_pkg::*;
#(
  parameter int MAX_IN_CHANNELS = MAX_IN_CHANNELS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int POS_W           = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  amx_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  amx_sts_t         sts,
  output amx_cmd_t         cmd,
  output logic [POS_W-1:0] pos
);

  localparam int ACC_W     = SAMPLE_BITS + $clog2(MAX_IN_CHANNELS) + 1;
  localparam int DIV_STEPS = ACC_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DLOAD, S_DIV, S_EMIT, S_PASS
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              last_r, last_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] slots;
  logic              emit_last;

  assign count     = frame_count(cfg.in_ch, MAX_IN_CHANNELS);
  assign slots     = slot_cnt(cfg.layout);
  assign emit_last = (slot_r == slots - 3'd1);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.slot  = slot_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = ({1'b0, 4'(pos_r)} + 5'd1 >= {1'b0, count});
          slot_nxt = '0;
          state_nxt = cfg.pass ? S_PASS : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (slot_r == SLOT_W'(NSLOT - 1)) begin
          slot_nxt = '0;
          if (!last_r) begin
            pos_nxt   = pos_r + POS_W'(1);
            state_nxt = S_IDLE;
          end else if (cfg.layout == LAYOUT_MONO) begin
            state_nxt = S_DLOAD;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          slot_nxt  = slot_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_DLOAD: begin
        cmd.div_start = 1'b1;
        dcnt_nxt      = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = emit_last;
          if (emit_last) begin
            cmd.clear = 1'b1;
            pos_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
        end
      end
      S_PASS: begin
        if (sts.out_free) begin
          cmd.pass  = 1'b1;
          cmd.last  = last_r;
          cmd.clear = last_r;
          pos_nxt   = last_r ? '0 : pos_r + POS_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, slot, channel position and divider count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      pos_r   <= '0;
      last_r  <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      pos_r   <= pos_nxt;
      last_r  <= last_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  assign pos = pos_r;

`ifndef SYNTHESIS
  // Never load a result over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.pass) |-> sts.out_free)
    else $error("result loaded while output register busy");

  // Accumulators clear only with the frame's last result
  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> ((cmd.emit || cmd.pass) && cmd.last))
    else $error("accumulator clear outside frame end");

  // Divider runs its full count before emission
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && state_nxt != S_DIV) |-> dcnt_r == DCNT_W'(DIV_STEPS - 1))
    else $error("divider left early");

  // Slot index stays within the accumulator bank
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(NSLOT - 1))
    else $error("slot index out of range");

  // Position returns to zero after a frame's last result
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> pos_r == '0)
    else $error("channel position not cleared at frame end");
`endif

endmodule

// File: hw/rtl/audio_channel_matrix_mixer.sv
// Channel   Direction  Fields
// in_*      slave      tdata: sample
// out_*     master     tdata: out_sample, out_channel; tlast: last_of_frame
// cfg_*     write      addr 0 output_layout, 1 channel count, 2 channel_map,
//                      3 passthrough
//
// Mixing accepts each input sample, then multiplies and accumulates it for
// each of the six output slots in turn through one shared multiplier. After
// the frame's last sample one result per slot of the layout is emitted, in
// mono after a divider load and SAMPLE_BITS + clog2(MAX_IN_CHANNELS) + 2 steps.
// Passthrough emits each sample as is. Reset is synchronous and active low.
// A stalled output holds emission; the next sample is taken while the last
// result of a frame still waits in the output register.
module audio_channel_matrix_mixer
  import amx_pkg::*;
#(
  parameter int MAX_IN_CHANNELS = MAX_IN_CHANNELS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  localparam int IN_TW          = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TW         = ((SAMPLE_BITS + CHAN_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,   // sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,  // out_sample, out_channel
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;

  amx_cfg_t                      cfg;
  amx_cmd_t                      cmd;
  amx_sts_t                      sts;
  logic [POS_W-1:0]              pos;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic [CHAN_W-1:0]             out_channel;

  amx_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  amx_ctrl #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .POS_W           (POS_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .pos      (pos)
  );

  amx_dp #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .POS_W           (POS_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .pos         (pos),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_sample),
    .out_channel (out_channel),
    .out_last    (out_tlast)
  );

  // Pack result fields, sample in the low bits
  assign out_tdata = OUT_TW'({out_channel, out_sample});

endmodule

// File: bench/tb_audio_channel_matrix_mixer.sv
module tb_audio_channel_matrix_mixer
  import amx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS   = 450;
  localparam int LAT_GUARD    = 80;     // covers a full mix pass plus the mono divider
  localparam int CHOKE_CYCLES = 250;
  localparam int DRAIN_LIMIT  = 20000;

  // Q1.15 gains
  localparam int G0 = 0;
  localparam int GU = 32768;
  localparam int GH = 23167;
  localparam int GF = 19497;
  localparam int GL = 16384;
  localparam int GT = 15041;

  // Gain per [layout-1][channel type][output slot]
  localparam int GAIN [0:6][0:9][0:5] = '{
    '{ '{GH,GH,G0,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GH,GH,G0,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GH,GH,G0,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GH,GH,G0,G0,G0,G0} },
    '{ '{GH,GH,G0,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GH,GH,G0,G0,G0,G0}, '{G0,G0,GU,G0,G0,G0}, '{G0,G0,GU,G0,G0,G0},
       '{G0,G0,GU,G0,G0,G0}, '{GH,G0,GH,G0,G0,G0}, '{G0,GH,GH,G0,G0,G0},
       '{GF,GF,GF,G0,G0,G0} },
    '{ '{G0,G0,GU,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{G0,G0,GU,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{G0,G0,GU,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GF,GF,GF,G0,G0,G0} },
    '{ '{G0,G0,G0,GU,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{G0,G0,G0,GU,G0,G0}, '{G0,G0,GU,G0,G0,G0}, '{G0,G0,GU,G0,G0,G0},
       '{G0,G0,GU,G0,G0,G0}, '{GH,G0,GH,G0,G0,G0}, '{G0,GH,GH,G0,G0,G0},
       '{GL,GL,GL,GL,G0,G0} },
    '{ '{GH,GH,G0,G0,G0,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{GH,GH,G0,G0,G0,G0}, '{G0,G0,GU,G0,G0,G0}, '{G0,G0,G0,GU,G0,G0},
       '{G0,G0,GH,GH,G0,G0}, '{GH,G0,GH,G0,G0,G0}, '{G0,GH,G0,GH,G0,G0},
       '{GL,GL,GL,GL,G0,G0} },
    '{ '{G0,G0,G0,G0,GU,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{G0,G0,G0,G0,GU,G0}, '{G0,G0,GU,G0,G0,G0}, '{G0,G0,G0,GU,G0,G0},
       '{G0,G0,GH,GH,G0,G0}, '{GH,G0,GH,G0,G0,G0}, '{G0,GH,G0,GH,G0,G0},
       '{GT,GT,GT,GT,GT,G0} },
    '{ '{G0,G0,G0,G0,GU,G0}, '{GU,G0,G0,G0,G0,G0}, '{G0,GU,G0,G0,G0,G0},
       '{G0,G0,G0,G0,GU,G0}, '{G0,G0,GU,G0,G0,G0}, '{G0,G0,G0,GU,G0,G0},
       '{G0,G0,GH,GH,G0,G0}, '{GH,G0,GH,G0,G0,G0}, '{G0,GH,G0,GH,G0,G0},
       '{G0,G0,G0,G0,G0,GU} }
  };

  localparam int SLOTS_OF [0:7] = '{1, 2, 3, 3, 4, 4, 5, 6};

  typedef struct {
    logic [23:0] smp;
    logic [2:0]  slot;
    logic        last;
  } mix_out_t;

  // Tracks mixer state and the output samples still owed
  class downmix_scoreboard;
    logic [2:0]  layout;
    logic [3:0]  chans;
    logic [31:0] cmap;
    logic        pass;
    logic [2:0]  pos;
    longint      acc [0:5];
    mix_out_t    owed [$];
    int          errors;
    int          n_in;
    int          n_out;

    function new();
      layout = LAYOUT_STEREO;
      chans  = 4'd2;
      cmap   = 32'd33;
      pass   = 1'b0;
      pos    = '0;
      foreach (acc[i]) acc[i] = 0;
      errors = 0;
      n_in   = 0;
      n_out  = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_LAYOUT:   layout = val[2:0];
        REG_CHANNELS: chans  = val[3:0];
        REG_MAP:      cmap   = val;
        REG_PASS:     pass   = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic [23:0] clip(longint v);
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[23:0];
    endfunction

    function longint scaled(longint v, int g);
      return (v * g + 16384) >>> 15;
    endfunction

    function void owe(logic [23:0] smp, logic [2:0] slot, logic last);
      mix_out_t r;
      r.smp  = smp;
      r.slot = slot;
      r.last = last;
      owed.push_back(r);
    endfunction

    // Sum a sample or queue it in passthrough; queue a frame's mix on its last channel
    function void take_sample(logic signed [23:0] x);
      longint v;
      longint a;
      longint m;
      longint q;
      int cnt;
      int typ;
      int den;
      int nslots;
      bit fin;
      v = x;
      n_in++;
      cnt = (chans == 0) ? 1 : (chans > 8) ? 8 : int'(chans);
      fin = (int'(pos) + 1 >= cnt);
      if (pass) begin
        owe(clip(v), pos, fin);
      end else if (layout == LAYOUT_MONO) begin
        acc[0] += v;
      end else begin
        typ = int'(cmap[4*pos +: 4]);
        if (typ < NTYPE) begin
          for (int s = 0; s < NSLOT; s++) begin
            if (GAIN[layout-1][typ][s] != 0)
              acc[s] += scaled(v, GAIN[layout-1][typ][s]);
          end
        end
      end
      if (fin) begin
        if (!pass) begin
          nslots = SLOTS_OF[layout];
          if (layout == LAYOUT_MONO) begin
            den = ((cnt + 1) / 2) * 2;
            a = acc[0];
            m = (a < 0) ? -a : a;
            q = (m + den / 2) / den;
            owe(clip((a < 0) ? -q : q), 3'd0, 1'b1);
          end else begin
            for (int s = 0; s < nslots; s++)
              owe(clip(acc[s]), 3'(s), s + 1 == nslots);
          end
        end
        foreach (acc[i]) acc[i] = 0;
        pos = '0;
      end else begin
        pos = pos + 3'd1;
      end
    endfunction

    // Compare one output transfer with the oldest owed sample
    function void match_output(logic [31:0] td, logic tl);
      mix_out_t want;
      n_out++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected output, got sample %0d channel %0d last %0b",
                 $time, $signed(td[23:0]), td[26:24], tl);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (td[23:0] !== want.smp) begin
        $display("%0t: out_sample mismatch, expected %0d, got %0d",
                 $time, $signed(want.smp), $signed(td[23:0]));
        errors++;
      end
      if (td[26:24] !== want.slot) begin
        $display("%0t: out_channel mismatch, expected %0d, got %0d",
                 $time, want.slot, td[26:24]);
        errors++;
      end
      if (tl !== want.last) begin
        $display("%0t: last_of_frame mismatch, expected %0b, got %0b",
                 $time, want.last, tl);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  downmix_scoreboard mixer = new();
  bit   choke_req = 1'b0;
  bit   sink_calm = 1'b0;
  bit   src_calm  = 1'b0;
  int   n_configs = 0;
  int   n_pass_cfg = 0;
  logic [7:0] layouts_hit = '0;

  audio_channel_matrix_mixer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [23:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 8) - 4);
      default: return 24'($urandom);
    endcase
  endfunction

  // Sample every output transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mixer.match_output(out_tdata, out_tlast);
  end

  // Output back-pressure, with a long hold-off on request
  initial begin : sink
    int hold;
    int gap;
    hold = 0;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        choke_req = 1'b0;
        hold = CHOKE_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
        gap = pick_gap(sink_calm);
      end
    end
  end

  // Offer one sample and hold it until the transfer
  task automatic push_sample(logic [23:0] x);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = x;
    do @(posedge clk); while (!in_tready);
    mixer.take_sample(x);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    mixer.set_reg(idx, val);
  endtask

  task automatic configure(logic [2:0] lay, logic [3:0] ch, logic [31:0] cmap, logic pass);
    write_reg(REG_LAYOUT, 32'(lay));
    write_reg(REG_CHANNELS, 32'(ch));
    write_reg(REG_MAP, cmap);
    write_reg(REG_PASS, 32'(pass));
    n_configs++;
    layouts_hit[lay] = 1'b1;
    if (pass) n_pass_cfg++;
  endtask

  // Pause the sender until every owed output is out and the datapath is quiet
  task automatic settle();
    in_tvalid = 1'b0;
    while (mixer.pending() != 0) @(negedge clk);
    repeat (LAT_GUARD) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int frames;
    int eff;
    int r;
    logic [2:0]  lay;
    logic [3:0]  ch;
    logic [31:0] cmap;
    logic        pass;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: stereo pair at full scale
    push_sample(24'h7fffff);
    push_sample(24'h800000);
    push_sample(24'h800000);
    push_sample(24'h7fffff);

    // Eight channels of types 0 to 7 into the widest layout, saturating
    settle();
    configure(LAYOUT_3F2R_L, 4'd8, 32'h7654_3210, 1'b0);
    repeat (8) push_sample(24'h7fffff);

    // Mono of one channel halves, ties away from zero; unknown types still sum
    settle();
    configure(LAYOUT_MONO, 4'd1, 32'hffff_ffff, 1'b0);
    push_sample(24'hfffffd);
    push_sample(24'h7fffff);
    push_sample(24'h800000);
    settle();
    write_reg(REG_CHANNELS, 32'd0);
    push_sample(24'd5);

    // Passthrough
    settle();
    configure(LAYOUT_STEREO, 4'd3, 32'h0, 1'b1);
    push_sample(24'h800000);
    push_sample(24'h7fffff);
    push_sample(24'd1);

    // Lower the channel count mid-frame: the next sample closes the frame
    settle();
    configure(LAYOUT_STEREO, 4'd4, 32'h0000_2121, 1'b0);
    push_sample(rand_sample());
    push_sample(rand_sample());
    push_sample(rand_sample());
    settle();
    write_reg(REG_CHANNELS, 32'd2);
    push_sample(rand_sample());

    // Random phases: walk all layouts first, then random settings
    phase = 0;
    while (mixer.n_in < 23 + RAND_ITEMS) begin
      settle();
      lay = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      r = $urandom_range(0, 19);
      ch = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : (r == 2) ? 4'($urandom_range(9, 14))
         : 4'($urandom_range(1, 8));
      r = $urandom_range(0, 19);
      if (r < 10) begin
        for (int i = 0; i < 8; i++) cmap[4*i +: 4] = 4'($urandom_range(0, 9));
      end else if (r < 16) begin
        cmap = $urandom;
      end else if (r < 18) begin
        cmap = 32'h0;
      end else begin
        cmap = 32'hffff_ffff;
      end
      pass = ($urandom_range(0, 99) < 15);
      configure(lay, ch, cmap, pass);
      src_calm = ($urandom_range(0, 3) == 0);
      if (phase == 3 || phase == 9) choke_req = 1'b1;
      eff = (ch == 0) ? 1 : (ch > 8) ? 8 : int'(ch);
      frames = $urandom_range(1, 5);
      repeat (frames * eff) push_sample(rand_sample());
      // occasionally stop mid-frame so the next setting lands on a partial frame
      if (eff > 1 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, eff - 1)) push_sample(rand_sample());
      phase++;
    end

    // Drain and check nothing is left owed
    in_tvalid = 1'b0;
    r = 0;
    while (mixer.pending() != 0 && r < DRAIN_LIMIT) begin
      @(negedge clk);
      r++;
    end
    repeat (LAT_GUARD) @(negedge clk);
    if (mixer.pending() != 0) begin
      $display("%0t: %0d output samples never arrived", $time, mixer.pending());
      mixer.errors++;
    end

    $display("covered %0d input and %0d output transfers over %0d settings",
             mixer.n_in, mixer.n_out, n_configs);
    $display("layouts hit %b, passthrough settings %0d, mismatches %0d",
             layouts_hit, n_pass_cfg, mixer.errors);
    if (mixer.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
